### design/pmfr_pkg.sv
`default_nettype none

package pmfr_pkg;

  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned START_W  = 12;
  localparam int unsigned LIMIT_W  = 13;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BASE_W   = 12;

  localparam int unsigned NUM_PAGES_DEF = 4096;
  localparam int unsigned WORD_BITS_DEF = 32;

  typedef enum logic [FUNC_W-1:0] {
    FN_MAP   = 2'd0,
    FN_UNMAP = 2'd1,
    FN_FIND  = 2'd2,
    FN_ALLOC = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_NOFIT    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_SET,
    OP_CLR,
    OP_FIND
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SETUP,
    S_RUN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic hit;
    logic conflict;
  } unit_flags_t;

endpackage

`default_nettype wire

### design/pmfr_if.sv
`default_nettype none

interface pmfr_req_if import pmfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [START_W-1:0] start_page;
  logic [LIMIT_W-1:0] limit_page;
  logic [COUNT_W-1:0] page_count;

  modport source (output valid, func, start_page, limit_page, page_count, input ready);
  modport sink   (input valid, func, start_page, limit_page, page_count, output ready);
endinterface

interface pmfr_rsp_if import pmfr_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BASE_W-1:0]   base_page;

  modport source (output valid, status, base_page, input ready);
  modport sink   (input valid, status, base_page, output ready);
endinterface

`default_nettype wire

### design/page_map_free_run_allocator.sv
// Flow: a request passes through setup, a run over the bitmap words of the run or
//   search window, and done; alloc adds a second pass over the run it marks.
// Throughput: one request at a time; one bitmap word per cycle through the shared word
//   unit and the RAM read port.
// Reset: asynchronous, active low; per-word valid bits clear the whole map at once.
`default_nettype none

module page_map_free_run_allocator import pmfr_pkg::*; #(
  parameter int unsigned NUM_PAGES = NUM_PAGES_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input wire       clk_i,
  input wire       rst_ni,
  pmfr_req_if.sink  req_i,
  pmfr_rsp_if.source rsp_o
);

  localparam int unsigned WORD_COUNT = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int unsigned PG_W       = WIDX_W + BIT_W;
  localparam int unsigned EXT_W      = ((PG_W > COUNT_W) ? PG_W : COUNT_W) + 1;

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  func_e                func_q;
  logic [START_W-1:0]   start_q;
  logic [LIMIT_W-1:0]   limit_q;
  logic [COUNT_W-1:0]   count_q;
  logic [PG_W-1:0]      lo_q, lo_d, hi_q, hi_d;
  logic [WIDX_W-1:0]    rd_w_q, rd_w_d, proc_w_q, proc_w_d;
  logic                 pend_q, pend_d, iss_done_q, iss_done_d;
  logic [COUNT_W-1:0]   run_q, run_d;
  logic                 conflict_q, conflict_d;
  status_e              st_q, st_d;
  logic [PG_W-1:0]      base_q, base_d;
  logic [WORD_COUNT-1:0] valid_q;

  logic                 rsp_valid_q;
  status_e              rsp_status_q;
  logic [BASE_W-1:0]    rsp_base_q;
  logic                 rsp_load;

  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_rdata, rd_word, unit_wdata;
  logic [COUNT_W-1:0]   unit_run;
  logic [PG_W-1:0]      unit_hit_page, unit_base;
  unit_flags_t          flags;

  logic [EXT_W-1:0]     start_x, end_x, map_top, map_last, limit_x, find_top, find_last;
  logic [EXT_W-1:0]     base_x;
  logic                 map_empty, find_empty;
  logic [WIDX_W-1:0]    hi_w;

  assign req_i.ready = (state_q == S_IDLE);

  assign start_x    = EXT_W'(start_q);
  assign end_x      = start_x + EXT_W'(count_q);
  assign map_top    = (end_x > EXT_W'(NUM_PAGES)) ? EXT_W'(NUM_PAGES) : end_x;
  assign map_last   = map_top - EXT_W'(1);
  assign map_empty  = (count_q == '0) || (start_x >= EXT_W'(NUM_PAGES));
  assign limit_x    = EXT_W'(limit_q);
  assign find_top   = (limit_q == '0 || limit_x > EXT_W'(NUM_PAGES)) ?
                      EXT_W'(NUM_PAGES) : limit_x;
  assign find_last  = find_top - EXT_W'(1);
  assign find_empty = (count_q == '0) || (start_x >= find_top);
  assign hi_w       = hi_q[PG_W-1:BIT_W];

  assign rd_word = valid_q[proc_w_q] ? ram_rdata : '0;

  pmfr_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (proc_w_q),
    .wdata_i (unit_wdata),
    .raddr_i (rd_w_q),
    .rdata_o (ram_rdata)
  );

  pmfr_word_unit #(
    .NUM_PAGES (NUM_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_unit (
    .word_i     (rd_word),
    .word_idx_i (proc_w_q),
    .lo_i       (lo_q),
    .hi_i       (hi_q),
    .count_i    (count_q),
    .run_i      (run_q),
    .op_i       (op_q),
    .wdata_o    (unit_wdata),
    .run_o      (unit_run),
    .hit_page_o (unit_hit_page),
    .base_o     (unit_base),
    .flags_o    (flags)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    rd_w_d     = rd_w_q;
    proc_w_d   = proc_w_q;
    pend_d     = 1'b0;
    iss_done_d = iss_done_q;
    run_d      = run_q;
    conflict_d = conflict_q;
    st_d       = st_q;
    base_d     = base_q;
    ram_we     = 1'b0;
    rsp_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        run_d      = '0;
        conflict_d = 1'b0;
        base_d     = '0;
        iss_done_d = 1'b0;
        lo_d       = start_x[PG_W-1:0];
        rd_w_d     = start_x[PG_W-1:BIT_W];
        if (func_q == FN_MAP || func_q == FN_UNMAP) begin
          op_d = (func_q == FN_MAP) ? OP_SET : OP_CLR;
          hi_d = map_last[PG_W-1:0];
          st_d = ST_OK;
          state_d = map_empty ? S_DONE : S_RUN;
        end else begin
          op_d = OP_FIND;
          hi_d = find_last[PG_W-1:0];
          if (find_empty) begin
            st_d    = ST_NOFIT;
            state_d = S_DONE;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (!iss_done_q) begin
          pend_d     = 1'b1;
          proc_w_d   = rd_w_q;
          rd_w_d     = rd_w_q + WIDX_W'(1);
          iss_done_d = (rd_w_q == hi_w);
        end
        if (pend_q) begin
          if (op_q != OP_FIND) begin
            ram_we     = 1'b1;
            conflict_d = conflict_q | flags.conflict;
            if (proc_w_q == hi_w) begin
              st_d    = (func_q == FN_MAP && conflict_d) ? ST_CONFLICT : ST_OK;
              state_d = S_DONE;
            end
          end else begin
            run_d = unit_run;
            if (flags.hit) begin
              base_d = unit_base;
              st_d   = ST_OK;
              if (func_q == FN_ALLOC) begin
                // second pass marks the found run
                op_d       = OP_SET;
                lo_d       = unit_base;
                hi_d       = unit_hit_page;
                rd_w_d     = unit_base[PG_W-1:BIT_W];
                pend_d     = 1'b0;
                iss_done_d = 1'b0;
              end else begin
                state_d = S_DONE;
              end
            end else if (proc_w_q == hi_w) begin
              st_d    = ST_NOFIT;
              base_d  = '0;
              state_d = S_DONE;
            end
          end
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_FIND;
      pend_q      <= 1'b0;
      iss_done_q  <= 1'b0;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      pend_q     <= pend_d;
      iss_done_q <= iss_done_d;
      if (ram_we) begin
        valid_q[proc_w_q] <= 1'b1;
      end
      if (rsp_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      func_q  <= func_e'(req_i.func);
      start_q <= req_i.start_page;
      limit_q <= req_i.limit_page;
      count_q <= req_i.page_count;
    end
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    rd_w_q     <= rd_w_d;
    proc_w_q   <= proc_w_d;
    run_q      <= run_d;
    conflict_q <= conflict_d;
    st_q       <= st_d;
    base_q     <= base_d;
    if (rsp_load) begin
      rsp_status_q <= st_q;
      rsp_base_q   <= base_x[BASE_W-1:0];
    end
  end

  assign base_x = EXT_W'(base_q);

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.status    = rsp_status_q;
  assign rsp_o.base_page = rsp_base_q;

  a_accept_setup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> (state_q == S_SETUP))
    else $error("accepted request did not start setup");

  a_write_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (proc_w_q >= lo_q[PG_W-1:BIT_W] && proc_w_q <= hi_w && op_q != OP_FIND))
    else $error("bitmap write outside run");

  a_hit_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && pend_q && op_q == OP_FIND && flags.hit) |->
    (unit_hit_page <= hi_q && unit_base >= lo_q))
    else $error("found run outside search window");

endmodule

`default_nettype wire

### design/pmfr_ram.sv
`default_nettype none

module pmfr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire               clk_i,
  input  wire               we_i,
  input  wire [ADDR_W-1:0]  waddr_i,
  input  wire [WIDTH-1:0]   wdata_i,
  input  wire [ADDR_W-1:0]  raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

### design/pmfr_word_unit.sv
`default_nettype none

module pmfr_word_unit import pmfr_pkg::*; #(
  parameter int unsigned NUM_PAGES = NUM_PAGES_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF,
  localparam int unsigned WORD_COUNT = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS,
  localparam int unsigned BIT_W      = $clog2(WORD_BITS),
  localparam int unsigned WIDX_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1,
  localparam int unsigned PG_W       = WIDX_W + BIT_W
) (
  input  wire [WORD_BITS-1:0] word_i,
  input  wire [WIDX_W-1:0]    word_idx_i,
  input  wire [PG_W-1:0]      lo_i,
  input  wire [PG_W-1:0]      hi_i,
  input  wire [COUNT_W-1:0]   count_i,
  input  wire [COUNT_W-1:0]   run_i,
  input  op_e                 op_i,
  output logic [WORD_BITS-1:0] wdata_o,
  output logic [COUNT_W-1:0]   run_o,
  output logic [PG_W-1:0]      hit_page_o,
  output logic [PG_W-1:0]      base_o,
  output unit_flags_t          flags_o
);

  localparam int unsigned RUN_W      = COUNT_W + 1;
  localparam int unsigned EXT_W      = ((PG_W > COUNT_W) ? PG_W : COUNT_W) + 1;

  logic [WIDX_W-1:0]    lo_w, hi_w;
  logic [BIT_W-1:0]     lo_b, hi_b;
  logic [WORD_BITS-1:0] in_rng;
  logic [WORD_BITS-1:0] blk;
  logic [WORD_BITS-1:0] therm;
  logic [WORD_BITS-1:0] hit_v;
  logic [BIT_W-1:0]     hit_j;
  logic                 hit;
  logic [RUN_W-1:0]     top_free;
  logic [RUN_W-1:0]     run_sum;
  logic [RUN_W-1:0]     run_n;
  logic [EXT_W-1:0]     page_ext;
  logic [EXT_W-1:0]     base_ext;

  assign lo_w = lo_i[PG_W-1:BIT_W];
  assign lo_b = lo_i[BIT_W-1:0];
  assign hi_w = hi_i[PG_W-1:BIT_W];
  assign hi_b = hi_i[BIT_W-1:0];

  // bits of this word inside [lo, hi]; blocked = outside or present
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      in_rng[i] = (word_idx_i != lo_w || BIT_W'(i) >= lo_b) &&
                  (word_idx_i != hi_w || BIT_W'(i) <= hi_b);
      therm[i]  = count_i > COUNT_W'(i);
    end
    blk = ~in_rng | word_i;
  end

  // bit j ends a fit when the last count pages up to j are free
  always_comb begin
    logic all_free;
    logic reach;
    for (int j = 0; j < WORD_BITS; j++) begin
      all_free = 1'b1;
      for (int i = 0; i <= j; i++) begin
        if (blk[i] && therm[j-i]) begin
          all_free = 1'b0;
        end
      end
      reach    = (RUN_W'(run_i) + RUN_W'(j + 1)) >= RUN_W'(count_i);
      hit_v[j] = all_free && reach;
    end
  end

  always_comb begin
    hit   = 1'b0;
    hit_j = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit_v[j]) begin
        hit   = 1'b1;
        hit_j = BIT_W'(j);
      end
    end
  end

  always_comb begin
    top_free = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (blk[i]) begin
        top_free = RUN_W'(WORD_BITS - 1 - i);
      end
    end
    run_sum = RUN_W'(run_i) + RUN_W'(WORD_BITS);
    run_n   = (|blk) ? top_free : run_sum;
  end

  assign run_o      = run_n[COUNT_W-1:0];
  assign hit_page_o = {word_idx_i, hit_j};
  assign page_ext   = EXT_W'(hit_page_o);
  assign base_ext   = page_ext + EXT_W'(1) - EXT_W'(count_i);
  assign base_o     = base_ext[PG_W-1:0];

  assign wdata_o = (op_i == OP_SET) ? (word_i | in_rng) : (word_i & ~in_rng);

  assign flags_o.hit      = hit;
  assign flags_o.conflict = |(word_i & in_rng);

endmodule

`default_nettype wire

### test/tb.sv
`default_nettype none

module tb;
  import pmfr_pkg::*;

  localparam int unsigned NUM_PAGES   = NUM_PAGES_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned TAIL_CYCLES = 300;

  typedef struct {
    status_e              status;
    logic [BASE_W-1:0]    base_page;
  } page_reply_t;

  typedef struct {
    int unsigned base;
    int unsigned count;
  } live_run_t;

  logic clk;
  logic rst_n;

  pmfr_req_if req_if ();
  pmfr_rsp_if rsp_if ();

  page_map_free_run_allocator i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  bit                page_present [NUM_PAGES];
  page_reply_t       pending_replies [$];
  live_run_t         live_runs [$];
  bit                idle_on;
  int unsigned       error_count;
  int unsigned       cycle_count;
  status_e           last_status;
  logic [BASE_W-1:0] last_base;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL page_map_free_run_allocator");
      $finish;
    end
  end

  // first-fit page map: map/unmap write a run, find/alloc scan the window
  function automatic void apply_page_op(input func_e fn, input int unsigned start,
                                        input int unsigned limit, input int unsigned count,
                                        output status_e st, output logic [BASE_W-1:0] base);
    int unsigned top;
    int unsigned run;
    int unsigned p;
    int unsigned first;
    bit          hit;
    bit          found;
    st    = ST_OK;
    base  = '0;
    hit   = 1'b0;
    found = 1'b0;
    run   = 0;
    first = 0;
    case (fn)
      FN_MAP, FN_UNMAP: begin
        for (int unsigned i = 0; i < count && start + i < NUM_PAGES; i++) begin
          hit |= page_present[start + i];
          page_present[start + i] = (fn == FN_MAP);
        end
        if (fn == FN_MAP && hit) st = ST_CONFLICT;
      end
      default: begin
        top = (limit == 0 || limit > NUM_PAGES) ? NUM_PAGES : limit;
        if (count != 0) begin
          for (p = start; p < top && !found; p++) begin
            if (page_present[p]) begin
              run = 0;
            end else begin
              run++;
              if (run >= count) begin
                found = 1'b1;
                first = p + 1 - count;
              end
            end
          end
        end
        if (found) begin
          base = first[BASE_W-1:0];
          if (fn == FN_ALLOC) begin
            for (int unsigned i = 0; i < count; i++) page_present[first + i] = 1'b1;
          end
        end else begin
          st = ST_NOFIT;
        end
      end
    endcase
  endfunction

  function automatic int unsigned draw_run_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 32);
    if (r < 95) return $urandom_range(33, 512);
    return $urandom_range(513, 4096);
  endfunction

  // leaves valid high on return; the next request or a pause decides about it
  task automatic send_page_op(input func_e fn, input int unsigned start,
                              input int unsigned limit, input int unsigned count,
                              output status_e st, output logic [BASE_W-1:0] base);
    int unsigned gap;
    page_reply_t reply;
    gap = idle_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.func       <= fn;
    req_if.start_page <= START_W'(start);
    req_if.limit_page <= LIMIT_W'(limit);
    req_if.page_count <= COUNT_W'(count);
    req_if.valid      <= 1'b1;
    do @(posedge clk); while (!req_if.ready);
    apply_page_op(fn, START_W'(start), LIMIT_W'(limit), COUNT_W'(count), st, base);
    reply.status    = st;
    reply.base_page = base;
    pending_replies.push_back(reply);
    @(negedge clk);
  endtask

  task automatic drain_requests();
    req_if.valid <= 1'b0;
    while (pending_replies.size() != 0) @(negedge clk);
  endtask

  initial begin
    int unsigned stall;
    page_reply_t want;
    rsp_if.ready <= 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      stall = idle_on ? $urandom_range(0, 17) : 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      if (pending_replies.size() == 0) begin
        $error("unexpected result: status %0d base_page %0d", rsp_if.status, rsp_if.base_page);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_if.status);
          error_count++;
        end
        if (rsp_if.base_page !== want.base_page) begin
          $error("base_page: expected %0d, got %0d", want.base_page, rsp_if.base_page);
          error_count++;
        end
      end
      @(negedge clk);
    end
  end

  task automatic test_map_runs();
    send_page_op(FN_MAP, 0, 0, 1, last_status, last_base);
    send_page_op(FN_MAP, 0, 0, 4, last_status, last_base);       // overlaps page 0
    send_page_op(FN_MAP, 4090, 0, 10, last_status, last_base);   // runs past the top
    send_page_op(FN_MAP, 4095, 0, 1, last_status, last_base);
    send_page_op(FN_MAP, 2000, 0, 0, last_status, last_base);    // zero count
  endtask

  task automatic test_unmap_runs();
    send_page_op(FN_UNMAP, 4090, 8191, 8191, last_status, last_base);
    send_page_op(FN_UNMAP, 0, 0, 0, last_status, last_base);
    send_page_op(FN_UNMAP, 0, 0, 4, last_status, last_base);
  endtask

  task automatic test_find_windows();
    send_page_op(FN_FIND, 0, 0, 1, last_status, last_base);
    send_page_op(FN_FIND, 0, 0, 0, last_status, last_base);
    send_page_op(FN_FIND, 100, 100, 1, last_status, last_base);  // empty window
    send_page_op(FN_FIND, 4095, 8191, 1, last_status, last_base); // limit above top
    send_page_op(FN_FIND, 0, 0, 4096, last_status, last_base);
    send_page_op(FN_FIND, 0, 0, 4097, last_status, last_base);
    send_page_op(FN_FIND, 4095, 4096, 2, last_status, last_base);
  endtask

  task automatic test_alloc_runs();
    send_page_op(FN_ALLOC, 0, 0, 4096, last_status, last_base);  // fills the map
    send_page_op(FN_ALLOC, 0, 0, 1, last_status, last_base);
    send_page_op(FN_UNMAP, 1000, 0, 3, last_status, last_base);
    send_page_op(FN_ALLOC, 0, 0, 3, last_status, last_base);
    send_page_op(FN_UNMAP, 0, 0, 4096, last_status, last_base);
    send_page_op(FN_ALLOC, 7, 20, 13, last_status, last_base);
    send_page_op(FN_ALLOC, 7, 20, 1, last_status, last_base);
    send_page_op(FN_MAP, 0, 0, 4096, last_status, last_base);
    send_page_op(FN_UNMAP, 0, 0, 8191, last_status, last_base);
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input bit with_idle);
    int unsigned r;
    int unsigned start;
    int unsigned limit;
    int unsigned count;
    int unsigned idx;
    live_run_t   run;
    idle_on = with_idle;
    repeat (n_items) begin
      r     = $urandom_range(0, 99);
      start = $urandom_range(0, NUM_PAGES - 1);
      count = draw_run_length();
      case ($urandom_range(0, 9))
        0, 1, 2:       limit = 0;
        3, 4, 5, 6, 7: limit = start + $urandom_range(1, 256);
        8:             limit = $urandom_range(NUM_PAGES + 1, 8191);
        default:       limit = $urandom_range(0, 8191);
      endcase
      if (r < 35) begin
        if ($urandom_range(0, 1)) start = 0;
        if ($urandom_range(0, 1)) limit = 0;
        send_page_op(FN_ALLOC, start, limit, count, last_status, last_base);
        if (last_status == ST_OK) begin
          run.base  = last_base;
          run.count = count;
          live_runs.push_back(run);
        end
      end else if (r < 60 && live_runs.size() != 0) begin
        idx = $urandom_range(0, live_runs.size() - 1);
        run = live_runs[idx];
        live_runs.delete(idx);
        send_page_op(FN_UNMAP, run.base, limit, run.count, last_status, last_base);
      end else if (r < 75) begin
        send_page_op(FN_FIND, start, limit, count, last_status, last_base);
      end else if (r < 85) begin
        send_page_op(FN_MAP, start, limit, count, last_status, last_base);
      end else if (r < 92) begin
        send_page_op(FN_UNMAP, start, limit, count, last_status, last_base);
      end else begin
        send_page_op(func_e'($urandom_range(0, 3)), start, $urandom_range(0, 8191),
                     $urandom_range(0, 8191), last_status, last_base);
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    req_if.valid      <= 1'b0;
    req_if.func       <= FN_MAP;
    req_if.start_page <= '0;
    req_if.limit_page <= '0;
    req_if.page_count <= '0;
    idle_on     = 1'b1;
    error_count = 0;
    cycle_count = 0;
    foreach (page_present[i]) page_present[i] = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_map_runs();
    test_unmap_runs();
    test_find_windows();
    test_alloc_runs();
    test_random_traffic(200, 1'b1);
    test_random_traffic(100, 1'b0);
    test_random_traffic(200, 1'b1);
    drain_requests();
    test_random_traffic(150, 1'b1);
    test_random_traffic(80, 1'b0);
    test_random_traffic(100, 1'b1);
    drain_requests();

    repeat (TAIL_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("PASS page_map_free_run_allocator");
    end else begin
      $display("FAIL page_map_free_run_allocator");
    end
    $finish;
  end

endmodule

`default_nettype wire
